[design/mbwr_pkg.sv]
// Shared types, codes and the CRC-16/MODBUS byte update for the Modbus
// write-single-register framer. No dependencies.
package mbwr_pkg;

    // Command opcodes carried on the input channel's tuser.
    localparam logic [2:0] OP_EXTEND  = 3'd0;
    localparam logic [2:0] OP_RETRACT = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_SPEED   = 3'd3;
    localparam logic [2:0] OP_PULSES  = 3'd4;

    // Holding register addresses (high byte is always zero).
    localparam logic [7:0] REG_ADDR_HI = 8'h00;
    localparam logic [7:0] REG_EXTEND  = 8'h01;
    localparam logic [7:0] REG_RETRACT = 8'h00;
    localparam logic [7:0] REG_STOP    = 8'h02;
    localparam logic [7:0] REG_SPEED   = 8'h05;
    localparam logic [7:0] REG_PULSES  = 8'h07;

    localparam logic [15:0] FIXED_VALUE      = 16'h0001;
    localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [7:0]  SLAVE_ADDR_RESET = 8'h01;

    // Byte positions within the frame.
    localparam logic [2:0] BYTE_ADDR     = 3'd0;
    localparam logic [2:0] BYTE_FUNC     = 3'd1;
    localparam logic [2:0] BYTE_REG_HI   = 3'd2;
    localparam logic [2:0] BYTE_REG_LO   = 3'd3;
    localparam logic [2:0] BYTE_VAL_HI   = 3'd4;
    localparam logic [2:0] BYTE_VAL_LO   = 3'd5;
    localparam logic [2:0] BYTE_CRC_LO   = 3'd6;
    localparam logic [2:0] BYTE_CRC_HI   = 3'd7;

    // Decoded command: register address low byte and value.
    typedef struct packed {
        logic [7:0]  reg_lo;
        logic [15:0] value;
    } cmd_t;

    // Fold one byte into a reflected CRC-16 (eight shift steps).
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[design/mbwr_front.sv]
// Front end of the framer: accepts commands, decodes opcodes into register
// and value, drops unknown opcodes. Depends on mbwr_pkg.
module mbwr_front import mbwr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    output logic        push_valid,
    input  logic        push_ready,
    output cmd_t        push_cmd
);

    logic stage_valid_reg;
    logic stage_valid_next;
    cmd_t stage_cmd_reg;
    cmd_t decoded;
    logic known;
    logic accept;

    always_comb begin
        known          = 1'b1;
        decoded.reg_lo = REG_RETRACT;
        decoded.value  = FIXED_VALUE;
        case (s_tuser)
            OP_EXTEND:  decoded.reg_lo = REG_EXTEND;
            OP_RETRACT: decoded.reg_lo = REG_RETRACT;
            OP_STOP:    decoded.reg_lo = REG_STOP;
            OP_SPEED: begin
                decoded.reg_lo = REG_SPEED;
                decoded.value  = s_tdata;
            end
            OP_PULSES: begin
                decoded.reg_lo = REG_PULSES;
                decoded.value  = s_tdata;
            end
            default:    known = 1'b0;
        endcase
    end

    assign s_tready   = !stage_valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = stage_valid_reg;
    assign push_cmd   = stage_cmd_reg;

    // Drop unknown opcodes here; hold a staged command until the queue takes it.
    assign stage_valid_next = accept ? known : (stage_valid_reg && !push_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_cmd_reg <= decoded;
        end
    end

endmodule

[design/mbwr_queue.sv]
// Short command queue between front and back ends of the framer.
// Depends on mbwr_pkg.
module mbwr_queue import mbwr_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/mbwr_back.sv]
// Back end of the framer: serialises one command into eight frame bytes,
// folding the CRC in as the bytes go out. Depends on mbwr_pkg.
module mbwr_back import mbwr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] slave_address,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  cmd_t       pop_cmd,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic        cmd_valid_reg;
    cmd_t        cmd_reg;
    logic [2:0]  idx_reg;
    logic [15:0] crc_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tlast_reg;
    logic [7:0]  byte_sel;
    logic        out_load;
    logic        at_last;
    logic        do_pop;

    always_comb begin
        case (idx_reg)
            BYTE_ADDR:   byte_sel = slave_address;
            BYTE_FUNC:   byte_sel = FUNC_WRITE_SINGLE;
            BYTE_REG_HI: byte_sel = REG_ADDR_HI;
            BYTE_REG_LO: byte_sel = cmd_reg.reg_lo;
            BYTE_VAL_HI: byte_sel = cmd_reg.value[15:8];
            BYTE_VAL_LO: byte_sel = cmd_reg.value[7:0];
            BYTE_CRC_LO: byte_sel = crc_reg[7:0];
            BYTE_CRC_HI: byte_sel = crc_reg[15:8];
            default:     byte_sel = crc_reg[15:8];
        endcase
    end

    // Advance one byte whenever the output register is free or draining.
    assign out_load  = cmd_valid_reg && (!m_tvalid_reg || m_tready);
    assign at_last   = (idx_reg == BYTE_CRC_HI);
    assign pop_ready = !cmd_valid_reg || (out_load && at_last);
    assign do_pop    = pop_valid && pop_ready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= BYTE_ADDR;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (do_pop) begin
                cmd_valid_reg <= 1'b1;
                idx_reg       <= BYTE_ADDR;
            end else if (out_load) begin
                cmd_valid_reg <= !at_last;
                idx_reg       <= idx_reg + 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop) begin
            cmd_reg <= pop_cmd;
            crc_reg <= CRC_INIT;
        end else if (out_load && (idx_reg < BYTE_CRC_LO)) begin
            crc_reg <= crc16_byte(crc_reg, byte_sel);
        end
        if (out_load) begin
            m_tdata_reg <= byte_sel;
            m_tlast_reg <= at_last;
        end
    end

    a_last_on_eighth: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && at_last) |=> m_tlast_reg)
        else $error("frame end not marked on the CRC high byte");

    a_no_early_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !at_last) |=> !m_tlast_reg)
        else $error("frame end marked before the CRC high byte");

    a_pop_only_between_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && cmd_valid_reg) |-> (out_load && at_last))
        else $error("new command loaded in the middle of a frame");

endmodule

[design/modbus_write_register_framer_unit.sv]
// Top level of the Modbus RTU write-single-register framer.
// Depends on mbwr_pkg, mbwr_front, mbwr_queue and mbwr_back.
//
// Input channel (s_*): one motor command per item. tuser carries the opcode
// (extend, retract, stop, set speed, set pulse count), tdata the 16-bit
// command value, used only by set speed and set pulse count. Opcodes 5 to 7
// are dropped and produce no bytes.
// Output channel (m_*): the eight bytes of one frame per command, one byte per
// item: address, function 0x06, register high/low, value high/low,
// CRC-16/MODBUS low then high. tlast marks the CRC high byte.
// Configuration: cfg_we writes cfg_wdata into the slave address on any clock
// edge; write it only while no frame is in flight.
// On an idle block an accepted command passes the front stage, the queue and
// the command register before its first byte enters the output register. One
// byte per cycle while m_tready is high, set by the byte-wide output register;
// frames of consecutive commands follow with no gap.
// A front stage and a QUEUE_DEPTH-entry queue accept commands while a frame is
// going out. When the receiver stalls, hold the current byte and fill the
// queue; s_tready falls once the queue and stage are full. Reset (synchronous)
// empties the queue, drops any frame in progress and sets the address to 1.
module modbus_write_register_framer_unit import mbwr_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Command input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] command_value
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    // Frame byte output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] frame_byte
    output logic        m_tlast,   // last_byte
    // Slave address register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    logic [7:0] slave_addr_reg;
    logic       push_valid;
    logic       push_ready;
    cmd_t       push_cmd;
    logic       pop_valid;
    logic       pop_ready;
    cmd_t       pop_cmd;

    // Hold the slave address; reset to device 1.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= SLAVE_ADDR_RESET;
        end else if (cfg_we) begin
            slave_addr_reg <= cfg_wdata;
        end
    end

    // Decode and stage commands.
    mbwr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Decouple decoding from serialisation.
    mbwr_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Serialise frames and append the CRC.
    mbwr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .slave_address (slave_addr_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_cmd       (pop_cmd),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

[tb/mbwr_frame_check.sv]
`timescale 1ns / 100ps
// Frame checker for the Modbus write-single-register framer: watches the
// command, byte and address-write ports, predicts every frame byte and
// compares. Depends on mbwr_pkg.
module mbwr_frame_check import mbwr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] command_value
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] frame_byte
    input  logic        m_tlast,   // last_byte
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output int          fail_count,
    output int          bytes_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    frame_byte_t expected_bytes[$];
    logic [7:0]  slave_addr = SLAVE_ADDR_RESET;

    // Build the eight bytes of one frame and queue them; reserved opcodes
    // give nothing.
    function automatic void queue_frame(input logic [2:0] op, input logic [15:0] val);
        logic [7:0]  reg_lo;
        logic [15:0] reg_val;
        logic [7:0]  frame [8];
        logic [15:0] crc;
        logic        fb;
        frame_byte_t fbyte;
        case (op)
            OP_EXTEND:  begin reg_lo = REG_EXTEND;  reg_val = FIXED_VALUE; end
            OP_RETRACT: begin reg_lo = REG_RETRACT; reg_val = FIXED_VALUE; end
            OP_STOP:    begin reg_lo = REG_STOP;    reg_val = FIXED_VALUE; end
            OP_SPEED:   begin reg_lo = REG_SPEED;   reg_val = val; end
            OP_PULSES:  begin reg_lo = REG_PULSES;  reg_val = val; end
            default:    return;
        endcase
        frame[0] = slave_addr;
        frame[1] = FUNC_WRITE_SINGLE;
        frame[2] = REG_ADDR_HI;
        frame[3] = reg_lo;
        frame[4] = reg_val[15:8];
        frame[5] = reg_val[7:0];
        // Bit-serial CRC, least significant bit of each byte first
        crc = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            for (int b = 0; b < 8; b++) begin
                fb  = crc[0] ^ frame[i][b];
                crc = crc >> 1;
                if (fb) begin
                    crc = crc ^ CRC_POLY;
                end
            end
        end
        frame[6] = crc[7:0];
        frame[7] = crc[15:8];
        for (int k = 0; k < 8; k++) begin
            fbyte.data = frame[k];
            fbyte.last = (k == 7);
            expected_bytes.push_back(fbyte);
        end
    endfunction

    always @(posedge aclk) begin
        frame_byte_t want;
        if (!aresetn) begin
            slave_addr = SLAVE_ADDR_RESET;
            expected_bytes.delete();
        end else begin
            if (cfg_we) begin
                slave_addr = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                queue_frame(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected frame byte %h (last %b)", m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data) begin
                        $error("frame_byte: expected %h, actual %h", want.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_byte: expected %b, actual %b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        bytes_pending <= expected_bytes.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Top of the framer testbench: clock, reset, command and address stimulus,
// receiver back-pressure and the verdict. Depends on mbwr_pkg, mbwr_frame_check
// and modbus_write_register_framer_unit.
module tb import mbwr_pkg::*;;

    // Opcodes outside the command set; the block drops them
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_MID   = 3'd6;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

    localparam int PHASE_ITEMS  = 56;
    localparam int DRAIN_CYCLES = 16;       // front stage, queue and first-byte latency
    localparam int CYCLE_LIMIT  = 400000;

    // Receiver back-pressure patterns
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [15:0] command_value
    logic [2:0]  s_tuser;    // [2:0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;    // [7:0] frame_byte
    logic        m_tlast;    // last_byte
    logic        cfg_we;
    logic [7:0]  cfg_wdata;

    int       fail_count;
    int       bytes_pending;
    int       cycle_count = 0;
    int       burst_left  = 1;
    rx_mode_t rx_mode     = RX_OPEN;
    int       rx_mode_left = 0;

    modbus_write_register_framer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    mbwr_frame_check checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .bytes_pending (bytes_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: abandon the run if it hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("modbus_write_register_framer_unit test failed");
            $finish;
        end
    end

    // Receiver: pick a back-pressure pattern, hold it for a random stretch
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= rx_mode_t'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(20, 200);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
            default:   m_tready <= ~m_tready;
        endcase
    end

    // Offer one command and hold it until accepted; close the burst with a
    // random gap when it runs out
    task automatic send_command(input logic [2:0] op, input logic [15:0] val);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Stop sending and wait until every predicted byte has come out, then let
    // any dropped command clear the pipeline
    task automatic drain_frames();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (bytes_pending != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_slave_addr(input logic [7:0] addr);
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [7:0] phase_addr [7];
        int         sent;

        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_EXTEND;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn   <= 1'b1;
        @(posedge aclk);

        // Directed: the speed and pulse-count opcodes at the value extremes, ignored
        // values on the fixed-value commands, and the reserved opcodes at reset address
        send_command(OP_EXTEND,  16'h0000);
        send_command(OP_RETRACT, 16'h0000);
        send_command(OP_STOP,    16'h0000);
        send_command(OP_EXTEND,  16'hFFFF);
        send_command(OP_RETRACT, 16'hAAAA);
        send_command(OP_STOP,    16'h5555);
        send_command(OP_SPEED,   16'h0000);
        send_command(OP_SPEED,   16'hFFFF);
        send_command(OP_SPEED,   16'h00FF);
        send_command(OP_SPEED,   16'hFF00);
        send_command(OP_PULSES,  16'h0000);
        send_command(OP_PULSES,  16'hFFFF);
        send_command(OP_PULSES,  16'h1234);
        send_command(OP_PULSES,  16'h8001);
        send_command(OP_RSVD_FIRST, 16'hFFFF);
        send_command(OP_RSVD_MID,   16'h0000);
        send_command(OP_RSVD_LAST,  16'h5A5A);
        send_command(OP_SPEED,   16'h5A5A);
        send_command(OP_PULSES,  16'hA5A5);
        // Hold off until the directed frames are all out
        drain_frames();

        phase_addr[0] = 8'h00;
        phase_addr[1] = 8'hFF;
        phase_addr[2] = 8'($urandom);
        phase_addr[3] = 8'hA5;
        phase_addr[4] = 8'h5A;
        phase_addr[5] = SLAVE_ADDR_RESET;
        phase_addr[6] = 8'($urandom);

        // Random: one address per phase, mostly real commands with the odd
        // reserved opcode and occasional full drains mid-phase
        foreach (phase_addr[p]) begin
            write_slave_addr(phase_addr[p]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_command(3'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST)),
                                 16'($urandom));
                end else begin
                    send_command(3'($urandom_range(OP_PULSES, OP_EXTEND)), pick_value());
                    sent++;
                end
                if ($urandom_range(0, 39) == 0) begin
                    drain_frames();
                end
            end
            drain_frames();
        end

        if (fail_count == 0) begin
            $display("modbus_write_register_framer_unit test passed");
        end else begin
            $display("modbus_write_register_framer_unit test failed");
        end
        $finish;
    end

endmodule

[modbus_write_register_framer_unit.f]
design/mbwr_pkg.sv
design/mbwr_front.sv
design/mbwr_queue.sv
design/mbwr_back.sv
design/modbus_write_register_framer_unit.sv
tb/mbwr_frame_check.sv
tb/tb.sv
